// ===== hdl/tlcd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlcd_pkg
// Shared types, codes and defaults of the two-tier LRU cache directory.
// ---------------------------------------------------------------------------
package tlcd_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int HOT_ENTRIES_DEF   = 16;

  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 40;
  localparam int STAMP_W = 32;
  localparam int OCC_W   = 41;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 4;
  localparam int EVICT_W = 7;
  localparam int HLIM_W  = 5;
  localparam int CFGI_W  = 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TOUCH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TRIM   = 3'd5;

  localparam logic [STAT_W-1:0] STS_HOT_HIT    = 4'd0;
  localparam logic [STAT_W-1:0] STS_PROMOTED   = 4'd1;
  localparam logic [STAT_W-1:0] STS_MISS       = 4'd2;
  localparam logic [STAT_W-1:0] STS_FETCH_FAIL = 4'd3;
  localparam logic [STAT_W-1:0] STS_TOO_LARGE  = 4'd4;
  localparam logic [STAT_W-1:0] STS_INSERTED   = 4'd5;
  localparam logic [STAT_W-1:0] STS_REMOVED    = 4'd6;
  localparam logic [STAT_W-1:0] STS_NOT_FOUND  = 4'd7;
  localparam logic [STAT_W-1:0] STS_TOUCHED    = 4'd8;
  localparam logic [STAT_W-1:0] STS_TRIMMED    = 4'd9;

  localparam logic [CFGI_W-1:0] CFG_BYTE_LIMIT = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_HOT_LIMIT  = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               hot;
    logic [KEY_W-1:0]   key;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic key_hit;
    logic free_found;
    logic old_found;
    logic hot_found;
  } scan_flags_t;

endpackage

// ===== hdl/tlcd_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlcd_if
// Command and result channels of the cache directory (valid/ready).
// ---------------------------------------------------------------------------
interface tlcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [tlcd_pkg::CMD_W-1:0]  cmd;
  logic [tlcd_pkg::KEY_W-1:0]  item_key;
  logic [tlcd_pkg::SIZE_W-1:0] item_size;
  logic                        fetch_ok;

  modport source (output valid, cmd, item_key, item_size, fetch_ok, input ready);
  modport sink (input valid, cmd, item_key, item_size, fetch_ok, output ready);
endinterface

interface tlcd_out_if;
  logic                         valid;
  logic                         ready;
  logic [tlcd_pkg::STAT_W-1:0]  status;
  logic [tlcd_pkg::SIZE_W-1:0]  occupied_bytes;
  logic [tlcd_pkg::EVICT_W-1:0] evicted_count;

  modport source (output valid, status, occupied_bytes, evicted_count, input ready);
  modport sink (input valid, status, occupied_bytes, evicted_count, output ready);
endinterface

// ===== hdl/tlcd_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlcd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tlcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tlcd_scan.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlcd_scan
// Accumulates one table sweep: key match, first free slot, oldest valid and
// oldest hot entry, and the number of valid entries.
// ---------------------------------------------------------------------------
module tlcd_scan #(
  parameter int TABLE_ENTRIES = tlcd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               start,
  input  logic                               en,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   idx,
  input  tlcd_pkg::entry_t                   word,
  input  logic [tlcd_pkg::KEY_W-1:0]         key,
  input  logic [tlcd_pkg::STAMP_W-1:0]       now,
  output tlcd_pkg::scan_flags_t              flags,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   key_idx,
  output tlcd_pkg::entry_t                   key_rec,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   free_idx,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   old_idx,
  output tlcd_pkg::entry_t                   old_rec,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   hot_idx,
  output tlcd_pkg::entry_t                   hot_rec,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] valid_cnt
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  tlcd_pkg::scan_flags_t           flags_r;
  logic [IW-1:0]                   key_idx_r, free_idx_r, old_idx_r, hot_idx_r;
  tlcd_pkg::entry_t                key_rec_r, old_rec_r, hot_rec_r;
  logic [tlcd_pkg::STAMP_W-1:0]    old_age_r, hot_age_r;
  logic [CW-1:0]                   valid_cnt_r;
  logic [tlcd_pkg::STAMP_W-1:0]    age;

  assign age = now - word.stamp;

  always_ff @(posedge clk) begin
    if (start) begin
      flags_r     <= '0;
      valid_cnt_r <= '0;
    end else if (en) begin
      if (word.valid) begin
        valid_cnt_r <= valid_cnt_r + CW'(1);
        if (!flags_r.key_hit && word.key == key) begin
          flags_r.key_hit <= 1'b1;
          key_idx_r       <= idx;
          key_rec_r       <= word;
        end
        if (!flags_r.old_found || age > old_age_r) begin
          flags_r.old_found <= 1'b1;
          old_idx_r         <= idx;
          old_rec_r         <= word;
          old_age_r         <= age;
        end
        if (word.hot && (!flags_r.hot_found || age > hot_age_r)) begin
          flags_r.hot_found <= 1'b1;
          hot_idx_r         <= idx;
          hot_rec_r         <= word;
          hot_age_r         <= age;
        end
      end else if (!flags_r.free_found) begin
        flags_r.free_found <= 1'b1;
        free_idx_r         <= idx;
      end
    end
  end

  assign flags     = flags_r;
  assign key_idx   = key_idx_r;
  assign key_rec   = key_rec_r;
  assign free_idx  = free_idx_r;
  assign old_idx   = old_idx_r;
  assign old_rec   = old_rec_r;
  assign hot_idx   = hot_idx_r;
  assign hot_rec   = hot_rec_r;
  assign valid_cnt = valid_cnt_r;

endmodule

// ===== hdl/two_tier_lru_cache_directory.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_tier_lru_cache_directory
// Keyed directory with a byte-bounded full tier and a count-bounded hot tier.
// ---------------------------------------------------------------------------
// All entries live in one RAM that is swept one entry per cycle. Every
// command first sweeps the table to find the key, the first free slot and
// the oldest entries, then writes back the entries that it changes. Each
// entry demoted from the hot tier and each entry evicted for the byte limit
// costs one more sweep; clear all adds a write pass over every entry. The
// next command is accepted from the cycle after the result is loaded. After
// reset the table is cleared before the first command is accepted. A result
// may wait in the output register while the next command is taken.
// ---------------------------------------------------------------------------
module two_tier_lru_cache_directory #(
  parameter int TABLE_ENTRIES = tlcd_pkg::TABLE_ENTRIES_DEF,
  parameter int HOT_ENTRIES   = tlcd_pkg::HOT_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tlcd_in_if.sink                     in_ch,
  tlcd_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [tlcd_pkg::CFGI_W-1:0] cfg_index,
  input  logic [tlcd_pkg::SIZE_W-1:0] cfg_wdata
);

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int HCW = $clog2(HOT_ENTRIES + 1);
  localparam int EW  = $bits(tlcd_pkg::entry_t);
  localparam int OW  = tlcd_pkg::OCC_W;

  localparam logic [3:0] S_INIT      = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_SCAN      = 4'd2;
  localparam logic [3:0] S_SCANW     = 4'd3;
  localparam logic [3:0] S_EXEC      = 4'd4;
  localparam logic [3:0] S_INS_WR    = 4'd5;
  localparam logic [3:0] S_MH_CHECK  = 4'd6;
  localparam logic [3:0] S_MH_STEP   = 4'd7;
  localparam logic [3:0] S_MH_DONE   = 4'd8;
  localparam logic [3:0] S_RED_CHECK = 4'd9;
  localparam logic [3:0] S_RED_STEP  = 4'd10;
  localparam logic [3:0] S_CLR       = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  localparam logic [1:0] PH_FIND = 2'd0;
  localparam logic [1:0] PH_HOT  = 2'd1;
  localparam logic [1:0] PH_RED  = 2'd2;

  logic [3:0]                           state_r, state_nxt;
  logic [1:0]                           phase_r, phase_nxt;
  logic [IW-1:0]                        addr_r, addr_nxt;
  logic                                 rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]                        rd_idx_r;
  logic [tlcd_pkg::CMD_W-1:0]           cmd_r, cmd_nxt;
  logic [tlcd_pkg::KEY_W-1:0]           key_r, key_nxt;
  logic [tlcd_pkg::SIZE_W-1:0]          size_r, size_nxt;
  logic                                 fetch_r, fetch_nxt;
  logic [tlcd_pkg::STAMP_W-1:0]         clock_r, clock_nxt;
  logic [OW-1:0]                        occ_r, occ_nxt;
  logic [HCW-1:0]                       hot_cnt_r, hot_cnt_nxt;
  logic [HCW-1:0]                       keep_r, keep_nxt;
  logic [tlcd_pkg::EVICT_W-1:0]         evict_r, evict_nxt;
  logic [IW-1:0]                        tgt_r, tgt_nxt;
  logic [tlcd_pkg::STAT_W-1:0]          status_r, status_nxt;
  logic [tlcd_pkg::SIZE_W-1:0]          byte_lim_r;
  logic [tlcd_pkg::HLIM_W-1:0]          hot_lim_r;
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 out_load;
  logic [tlcd_pkg::STAT_W-1:0]          out_status_r;
  logic [tlcd_pkg::SIZE_W-1:0]          out_occ_r;
  logic [tlcd_pkg::EVICT_W-1:0]         out_evict_r;

  logic                                 mem_we, mem_re, scan_start;
  logic [IW-1:0]                        mem_waddr;
  tlcd_pkg::entry_t                     mem_wdata, mem_rdata;
  logic [EW-1:0]                        mem_rbits;

  tlcd_pkg::scan_flags_t                fl;
  logic [IW-1:0]                        key_idx, free_idx, old_idx, hot_idx;
  tlcd_pkg::entry_t                     key_rec, old_rec, hot_rec;
  logic [CW-1:0]                        valid_cnt;

  logic [HCW-1:0]                       eff_lim;
  logic                                 addr_last;

  function automatic logic [OW-1:0] occ_sub(input logic [OW-1:0] occ,
                                            input logic [tlcd_pkg::SIZE_W-1:0] sz);
    logic [OW-1:0] s;
    s = {1'b0, sz};
    return (s > occ) ? '0 : occ - s;
  endfunction

  function automatic logic [HCW-1:0] hot_dec(input logic [HCW-1:0] c);
    return (c != '0) ? c - HCW'(1) : c;
  endfunction

  function automatic logic [tlcd_pkg::EVICT_W-1:0] ev_inc(
      input logic [tlcd_pkg::EVICT_W-1:0] e);
    return (&e) ? e : e + tlcd_pkg::EVICT_W'(1);
  endfunction

  assign eff_lim = (hot_lim_r == '0 || 32'(hot_lim_r) > 32'(HOT_ENTRIES))
                   ? HCW'(HOT_ENTRIES) : HCW'(hot_lim_r);
  assign addr_last = (addr_r == IW'(TABLE_ENTRIES - 1));

  tlcd_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_r),
    .rdata (mem_rbits)
  );

  assign mem_rdata = tlcd_pkg::entry_t'(mem_rbits);

  tlcd_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_scan (
    .clk       (clk),
    .start     (scan_start),
    .en        (rd_pend_r),
    .idx       (rd_idx_r),
    .word      (mem_rdata),
    .key       (key_r),
    .now       (clock_r),
    .flags     (fl),
    .key_idx   (key_idx),
    .key_rec   (key_rec),
    .free_idx  (free_idx),
    .old_idx   (old_idx),
    .old_rec   (old_rec),
    .hot_idx   (hot_idx),
    .hot_rec   (hot_rec),
    .valid_cnt (valid_cnt)
  );

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.occupied_bytes = out_occ_r;
  assign out_ch.evicted_count = out_evict_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    addr_nxt      = addr_r;
    rd_pend_nxt   = 1'b0;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    size_nxt      = size_r;
    fetch_nxt     = fetch_r;
    clock_nxt     = clock_r;
    occ_nxt       = occ_r;
    hot_cnt_nxt   = hot_cnt_r;
    keep_nxt      = keep_r;
    evict_nxt     = evict_r;
    tgt_nxt       = tgt_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = '0;
    scan_start    = 1'b0;

    case (state_r)
      S_INIT: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + IW'(1);
        if (addr_last) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt    = in_ch.cmd;
          key_nxt    = in_ch.item_key;
          size_nxt   = in_ch.item_size;
          fetch_nxt  = in_ch.fetch_ok;
          evict_nxt  = '0;
          scan_start = 1'b1;
          addr_nxt   = '0;
          phase_nxt  = PH_FIND;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        mem_re      = 1'b1;
        rd_pend_nxt = 1'b1;
        addr_nxt    = addr_r + IW'(1);
        if (addr_last) begin
          addr_nxt  = '0;
          state_nxt = S_SCANW;
        end
      end
      S_SCANW: begin
        case (phase_r)
          PH_FIND: state_nxt = S_EXEC;
          PH_HOT:  state_nxt = S_MH_STEP;
          default: state_nxt = S_RED_STEP;
        endcase
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (cmd_r)
          tlcd_pkg::CMD_INSERT: begin
            if (size_r > byte_lim_r) begin
              status_nxt = tlcd_pkg::STS_TOO_LARGE;
            end else begin
              state_nxt = S_INS_WR;
              if (fl.key_hit) begin
                mem_we          = 1'b1;
                mem_waddr       = key_idx;
                mem_wdata       = key_rec;
                mem_wdata.valid = 1'b0;
                mem_wdata.hot   = 1'b0;
                occ_nxt         = occ_sub(occ_r, key_rec.size);
                if (key_rec.hot) begin
                  hot_cnt_nxt = hot_dec(hot_cnt_r);
                end
                tgt_nxt = (fl.free_found && free_idx < key_idx) ? free_idx : key_idx;
              end else if (fl.free_found) begin
                tgt_nxt = free_idx;
              end else begin
                tgt_nxt   = fl.old_found ? old_idx : '0;
                occ_nxt   = occ_sub(occ_r, old_rec.size);
                evict_nxt = ev_inc(evict_r);
                if (old_rec.hot) begin
                  hot_cnt_nxt = hot_dec(hot_cnt_r);
                end
              end
            end
          end
          tlcd_pkg::CMD_GET: begin
            if (!fl.key_hit) begin
              status_nxt = tlcd_pkg::STS_MISS;
            end else if (key_rec.hot) begin
              mem_we          = 1'b1;
              mem_waddr       = key_idx;
              mem_wdata       = key_rec;
              mem_wdata.stamp = clock_r;
              clock_nxt       = clock_r + 32'd1;
              status_nxt      = tlcd_pkg::STS_HOT_HIT;
            end else if (fetch_r) begin
              keep_nxt  = eff_lim - HCW'(1);
              state_nxt = S_MH_CHECK;
            end else begin
              mem_we          = 1'b1;
              mem_waddr       = key_idx;
              mem_wdata       = key_rec;
              mem_wdata.valid = 1'b0;
              occ_nxt         = occ_sub(occ_r, key_rec.size);
              status_nxt      = tlcd_pkg::STS_FETCH_FAIL;
            end
          end
          tlcd_pkg::CMD_REMOVE: begin
            if (fl.key_hit) begin
              mem_we          = 1'b1;
              mem_waddr       = key_idx;
              mem_wdata       = key_rec;
              mem_wdata.valid = 1'b0;
              mem_wdata.hot   = 1'b0;
              occ_nxt         = occ_sub(occ_r, key_rec.size);
              if (key_rec.hot) begin
                hot_cnt_nxt = hot_dec(hot_cnt_r);
              end
              status_nxt = tlcd_pkg::STS_REMOVED;
            end else begin
              status_nxt = tlcd_pkg::STS_NOT_FOUND;
            end
          end
          tlcd_pkg::CMD_TOUCH: begin
            if (fl.key_hit) begin
              mem_we          = 1'b1;
              mem_waddr       = key_idx;
              mem_wdata       = key_rec;
              mem_wdata.stamp = clock_r;
              clock_nxt       = clock_r + 32'd1;
              status_nxt      = tlcd_pkg::STS_TOUCHED;
            end else begin
              status_nxt = tlcd_pkg::STS_NOT_FOUND;
            end
          end
          tlcd_pkg::CMD_CLEAR: begin
            evict_nxt   = (32'(valid_cnt) > 32'd127) ? '1 : tlcd_pkg::EVICT_W'(valid_cnt);
            occ_nxt     = '0;
            hot_cnt_nxt = '0;
            addr_nxt    = '0;
            state_nxt   = S_CLR;
          end
          tlcd_pkg::CMD_TRIM: begin
            state_nxt = S_RED_CHECK;
          end
          default: begin
            status_nxt = tlcd_pkg::STS_NOT_FOUND;
          end
        endcase
      end
      S_INS_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = tgt_r;
        mem_wdata.valid = 1'b1;
        mem_wdata.hot   = 1'b0;
        mem_wdata.key   = key_r;
        mem_wdata.size  = size_r;
        mem_wdata.stamp = clock_r;
        clock_nxt       = clock_r + 32'd1;
        occ_nxt         = occ_r + {1'b0, size_r};
        keep_nxt        = eff_lim - HCW'(1);
        state_nxt       = S_MH_CHECK;
      end
      S_MH_CHECK: begin
        if (hot_cnt_r > keep_r) begin
          scan_start = 1'b1;
          addr_nxt   = '0;
          phase_nxt  = PH_HOT;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_MH_DONE;
        end
      end
      S_MH_STEP: begin
        if (fl.hot_found) begin
          mem_we        = 1'b1;
          mem_waddr     = hot_idx;
          mem_wdata     = hot_rec;
          mem_wdata.hot = 1'b0;
          hot_cnt_nxt   = hot_dec(hot_cnt_r);
        end else begin
          hot_cnt_nxt = '0;
        end
        state_nxt = S_MH_CHECK;
      end
      S_MH_DONE: begin
        case (cmd_r)
          tlcd_pkg::CMD_INSERT: begin
            mem_we          = 1'b1;
            mem_waddr       = tgt_r;
            mem_wdata.valid = 1'b1;
            mem_wdata.hot   = 1'b1;
            mem_wdata.key   = key_r;
            mem_wdata.size  = size_r;
            mem_wdata.stamp = clock_r - 32'd1;
            hot_cnt_nxt     = hot_cnt_r + HCW'(1);
            state_nxt       = S_RED_CHECK;
          end
          tlcd_pkg::CMD_GET: begin
            mem_we          = 1'b1;
            mem_waddr       = key_idx;
            mem_wdata       = key_rec;
            mem_wdata.hot   = 1'b1;
            mem_wdata.stamp = clock_r;
            clock_nxt       = clock_r + 32'd1;
            hot_cnt_nxt     = hot_cnt_r + HCW'(1);
            status_nxt      = tlcd_pkg::STS_PROMOTED;
            state_nxt       = S_DONE;
          end
          default: begin
            status_nxt = tlcd_pkg::STS_TRIMMED;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_RED_CHECK: begin
        if (occ_r > {1'b0, byte_lim_r}) begin
          scan_start = 1'b1;
          addr_nxt   = '0;
          phase_nxt  = PH_RED;
          state_nxt  = S_SCAN;
        end else if (cmd_r == tlcd_pkg::CMD_INSERT) begin
          status_nxt = tlcd_pkg::STS_INSERTED;
          state_nxt  = S_DONE;
        end else begin
          keep_nxt  = eff_lim;
          state_nxt = S_MH_CHECK;
        end
      end
      S_RED_STEP: begin
        if (fl.old_found) begin
          mem_we          = 1'b1;
          mem_waddr       = old_idx;
          mem_wdata       = old_rec;
          mem_wdata.valid = 1'b0;
          mem_wdata.hot   = 1'b0;
          occ_nxt         = occ_sub(occ_r, old_rec.size);
          evict_nxt       = ev_inc(evict_r);
          if (old_rec.hot) begin
            hot_cnt_nxt = hot_dec(hot_cnt_r);
          end
        end else begin
          occ_nxt = '0;
        end
        state_nxt = S_RED_CHECK;
      end
      S_CLR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + IW'(1);
        if (addr_last) begin
          addr_nxt   = '0;
          status_nxt = tlcd_pkg::STS_TRIMMED;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      phase_r     <= PH_FIND;
      addr_r      <= '0;
      rd_pend_r   <= 1'b0;
      clock_r     <= '0;
      occ_r       <= '0;
      hot_cnt_r   <= '0;
      byte_lim_r  <= '0;
      hot_lim_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      addr_r      <= addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      clock_r     <= clock_nxt;
      occ_r       <= occ_nxt;
      hot_cnt_r   <= hot_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == tlcd_pkg::CFG_BYTE_LIMIT) begin
          byte_lim_r <= cfg_wdata;
        end else begin
          hot_lim_r <= cfg_wdata[tlcd_pkg::HLIM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= addr_r;
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    size_r   <= size_nxt;
    fetch_r  <= fetch_nxt;
    keep_r   <= keep_nxt;
    evict_r  <= evict_nxt;
    tgt_r    <= tgt_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_occ_r    <= occ_r[tlcd_pkg::SIZE_W-1:0];
      out_evict_r  <= evict_r;
    end
  end

  a_hot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hot_cnt_r <= HCW'(HOT_ENTRIES))
    else $error("hot count above hot tier capacity");

  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("table read and write in the same cycle");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("table written while idle");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_SCAN))
    else $error("accepted transaction did not start a sweep");

endmodule
